### design/csvs_pkg.sv
// ----------------------------------------------------------------------------
// csvs_pkg
// shared types and character codes for the csv field splitter
// ----------------------------------------------------------------------------
package csvs_pkg;

  localparam int unsigned ByteBits     = 8;
  localparam int unsigned OutIndexBits = 16;
  localparam int unsigned CfgIdxBits   = 2;

  localparam logic [ByteBits-1:0] ChCr    = 8'h0D;
  localparam logic [ByteBits-1:0] ChLf    = 8'h0A;
  localparam logic [ByteBits-1:0] ChQuote = 8'h22;
  localparam logic [ByteBits-1:0] ChComma = 8'h2C;
  localparam logic [ByteBits-1:0] ChDot   = 8'h2E;

  localparam logic [ByteBits-1:0] SeparatorReset = 8'h2C;
  localparam logic                CrModeReset    = 1'b0;
  localparam logic                CommaDotReset  = 1'b1;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgSeparator  = 2'd0,
    CfgCrMode     = 2'd1,
    CfgCommaToDot = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteBits-1:0] in_byte;
    logic                end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [ByteBits-1:0]     out_byte;
    logic                    is_data;
    logic                    field_end;
    logic                    line_end;
    logic [OutIndexBits-1:0] field_index;
  } out_item_t;

  typedef struct packed {
    logic [ByteBits-1:0] separator;
    logic                cr_mode;
    logic                comma_to_dot;
  } cfg_t;

endpackage

### design/csvs_core.sv
// ----------------------------------------------------------------------------
// csvs_core
// per-byte parse state machine: one transaction per enabled cycle
// ----------------------------------------------------------------------------
module csvs_core #(
  parameter int unsigned FIELD_INDEX_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  csvs_pkg::in_item_t  item_i,
  input  csvs_pkg::cfg_t      cfg_i,
  output logic                has_result_o,
  output csvs_pkg::out_item_t result_o
);

  typedef enum logic [1:0] {
    PhStart  = 2'd0,
    PhCopy   = 2'd1,
    PhQuoted = 2'd2,
    PhQpend  = 2'd3
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic                        subst_q, subst_d;
  logic                        prev_cr_q, prev_cr_d;
  logic                        line_bytes_q, line_bytes_d;
  logic [FIELD_INDEX_BITS-1:0] field_q, field_d;

  logic [csvs_pkg::ByteBits-1:0] b;
  logic                          copy_rule;

  assign b = item_i.in_byte;

  always_comb begin
    phase_d      = phase_q;
    subst_d      = subst_q;
    prev_cr_d    = prev_cr_q;
    line_bytes_d = line_bytes_q;
    field_d      = field_q;
    has_result_o = 1'b0;
    copy_rule    = 1'b0;
    result_o             = '0;
    result_o.field_index = csvs_pkg::OutIndexBits'(field_q);

    if (item_i.end_of_data) begin
      prev_cr_d = 1'b0;
      if (line_bytes_q) begin
        has_result_o       = 1'b1;
        result_o.field_end = 1'b1;
        result_o.line_end  = 1'b1;
      end
      phase_d      = PhStart;
      subst_d      = 1'b0;
      line_bytes_d = 1'b0;
      field_d      = '0;
    end else if (b == csvs_pkg::ChCr || (b == csvs_pkg::ChLf && !prev_cr_q)) begin
      prev_cr_d = 1'b0;
      if (!(b == csvs_pkg::ChCr && cfg_i.cr_mode)) begin
        has_result_o       = 1'b1;
        result_o.field_end = line_bytes_q;
        result_o.line_end  = 1'b1;
        phase_d            = PhStart;
        subst_d            = 1'b0;
        line_bytes_d       = 1'b0;
        field_d            = '0;
        prev_cr_d          = (b == csvs_pkg::ChCr);
      end
    end else if (b == csvs_pkg::ChLf) begin
      // lf right after cr is swallowed
      prev_cr_d = 1'b0;
    end else begin
      prev_cr_d    = 1'b0;
      line_bytes_d = 1'b1;
      case (phase_q)
        PhStart: begin
          if (b == csvs_pkg::ChQuote) begin
            phase_d = PhQuoted;
            subst_d = cfg_i.comma_to_dot;
          end else if (b == cfg_i.separator) begin
            copy_rule = 1'b1;
          end else begin
            phase_d           = PhCopy;
            has_result_o      = 1'b1;
            result_o.is_data  = 1'b1;
            result_o.out_byte = b;
          end
        end
        PhQuoted: begin
          if (b == csvs_pkg::ChQuote) begin
            phase_d = PhQpend;
            subst_d = 1'b0;
          end else begin
            has_result_o      = 1'b1;
            result_o.is_data  = 1'b1;
            result_o.out_byte = (subst_q && b == csvs_pkg::ChComma) ? csvs_pkg::ChDot : b;
          end
        end
        PhQpend: begin
          if (b == csvs_pkg::ChQuote) begin
            phase_d           = PhQuoted;
            has_result_o      = 1'b1;
            result_o.is_data  = 1'b1;
            result_o.out_byte = b;
          end else begin
            phase_d   = PhCopy;
            copy_rule = 1'b1;
          end
        end
        default: begin
          copy_rule = 1'b1;
        end
      endcase

      if (copy_rule) begin
        has_result_o = 1'b1;
        if (b == cfg_i.separator) begin
          result_o.field_end = 1'b1;
          phase_d            = PhStart;
          subst_d            = 1'b0;
          if (field_q != '1) begin
            field_d = field_q + 1'b1;
          end
        end else begin
          result_o.is_data  = 1'b1;
          result_o.out_byte = b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart;
      subst_q      <= 1'b0;
      prev_cr_q    <= 1'b0;
      line_bytes_q <= 1'b0;
      field_q      <= '0;
    end else if (step_i) begin
      phase_q      <= phase_d;
      subst_q      <= subst_d;
      prev_cr_q    <= prev_cr_d;
      line_bytes_q <= line_bytes_d;
      field_q      <= field_d;
    end
  end

endmodule

### design/csvs_out_fifo.sv
// ----------------------------------------------------------------------------
// csvs_out_fifo
// two-entry result buffer decoupling the parser from output stall
// ----------------------------------------------------------------------------
module csvs_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csvs_pkg::out_item_t push_data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output csvs_pkg::out_item_t out_data_o
);

  csvs_pkg::out_item_t mem_q [2];
  logic                wr_ptr_q, rd_ptr_q;
  logic [1:0]          count_q;
  logic                pop;

  assign full_o      = count_q[1];
  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

### design/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// csv_field_splitter
// streaming csv splitter: one text byte or end-of-data mark per transaction
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_stall_o carry one byte or end-of-data mark.
// output channel: out_valid_o / out_stall_i carry field bytes and markers for
// field ends and line ends, tagged with the field index within the line.
// an input transaction gives zero or one output transaction.
// a result passes from the input register through the parse logic into the
// result buffer. throughput: one byte per cycle while the buffer is not
// full, set by the single parse state machine.
// when the receiver stalls, the result buffer absorbs up to two results;
// the input stalls only while the buffer is full and the input register holds
// a pending transaction.
// reset clears the parse state and buffer; separator returns to comma,
// cr_mode to 0 and comma_to_dot to 1.
// configuration writes (cfg_we_i) are applied at once and expected only
// while the block is idle.
// ----------------------------------------------------------------------------
module csv_field_splitter #(
  parameter int unsigned FIELD_INDEX_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  csvs_pkg::in_item_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output csvs_pkg::out_item_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [csvs_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [csvs_pkg::ByteBits-1:0]       cfg_data_i
);

  csvs_pkg::cfg_t      cfg_q;
  csvs_pkg::in_item_t  item_q;
  logic                item_valid_q;
  logic                fifo_full;
  logic                step;
  logic                has_result;
  csvs_pkg::out_item_t result;

  assign in_stall_o = item_valid_q && fifo_full;
  assign step       = item_valid_q && !fifo_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.separator    <= csvs_pkg::SeparatorReset;
      cfg_q.cr_mode      <= csvs_pkg::CrModeReset;
      cfg_q.comma_to_dot <= csvs_pkg::CommaDotReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csvs_pkg::CfgSeparator:  cfg_q.separator    <= cfg_data_i;
        csvs_pkg::CfgCrMode:     cfg_q.cr_mode      <= cfg_data_i[0];
        csvs_pkg::CfgCommaToDot: cfg_q.comma_to_dot <= cfg_data_i[0];
        default:                 cfg_q              <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  csvs_core #(
    .FIELD_INDEX_BITS(FIELD_INDEX_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .has_result_o(has_result),
    .result_o    (result)
  );

  csvs_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step && has_result),
    .push_data_i(result),
    .full_o     (fifo_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
